>>> src/lprr_pkg.sv
`timescale 1ns / 1ps

package lprr_pkg;

	localparam int KIND_W       = 3;
	localparam int LEN_W        = 6;
	localparam int BYTE_W       = 8;
	localparam int STATUS_W     = 2;
	localparam int FREE_BYTES_W = 9;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 24;
	localparam int OUT_TUSER_W  = 3;

	localparam logic [KIND_W-1:0] KIND_BEGIN = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DATA  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOROOM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_ORDER  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HDR_WR,
		ST_HDR_RD,
		ST_LEN,
		ST_DATA_RD,
		ST_DRAIN,
		ST_RESULT
	} lprr_state_t;

endpackage

>>> src/lprr_ram.sv
`timescale 1ns / 1ps

module lprr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/length_prefixed_record_ring_top.sv
`timescale 1ns / 1ps

// Byte ring of RING_BYTES bytes holding records, each a little-endian length header of
// HEADER_BYTES bytes followed by its data, both wrapping at the end of the ring.
// Requests arrive on the s_axis channel, one at a time; the kind travels in tuser.
// A begin-push request reserves header plus data and writes the header; the announced
// data bytes then follow as push-data requests. Pop and peek with bytes to deliver
// return one result per delivered byte on m_axis, tlast on the final one; every other
// request returns one status result with tlast set.
// All state apart from the counters lives in a single-port-write, single-port-read ring
// memory, so each request takes its bytes through that memory one per cycle, byte reads
// pausing while the output has no room: begin push writes the header and then returns
// its result, pop or peek reads the header, works out the length and then reads the
// delivered bytes.
// Byte reads are issued only when the output register or its one-entry skid stage has
// room, so a stalled receiver simply pauses delivery without losing bytes.
// A new request is taken as soon as the previous one has handed over its last result,
// even while that result still waits in the output register.
// Reset empties the ring at once; the memory contents are not cleared and need no pass.
module length_prefixed_record_ring_top
	import lprr_pkg::*;
#(
	parameter int RING_BYTES   = 256,
	parameter int HEADER_BYTES = 8,
	parameter int MAX_RECORD   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// record_length [5:0], max_length [11:6], push_byte [19:12], zero [23:20]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind [2:0]
	input  logic [KIND_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_byte [7:0], free_bytes [16:8], is_empty [17], zero [23:18]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status [1:0], byte_valid [2]
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,
	output logic                   m_axis_tlast
);

	localparam int AW  = $clog2(RING_BYTES);
	localparam int FW  = $clog2(RING_BYTES + 1);
	localparam int HCW = $clog2(HEADER_BYTES + 1);
	localparam int LW  = $clog2(MAX_RECORD + 1);
	localparam int SW  = AW + 8;
	localparam int CW  = FW + 8;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		ring_next = (p == AW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
	endfunction

	lprr_state_t state_q, state_d;

	logic [KIND_W-1:0]   kind_q, kind_d;
	logic [LEN_W-1:0]    rec_len_q, rec_len_d;
	logic [LEN_W-1:0]    max_len_q, max_len_d;
	logic [BYTE_W-1:0]   byte_q, byte_d;
	logic [STATUS_W-1:0] status_q, status_d;

	logic [AW-1:0]    rp_q, rp_d, wp_q, wp_d, scan_q, scan_d;
	logic [FW-1:0]    free_q, free_d;
	logic             push_open_q, push_open_d;
	logic [LEN_W-1:0] push_rem_q, push_rem_d;

	logic [HCW-1:0]    hcnt_q, hcnt_d, hrcv_q, hrcv_d;
	logic [BYTE_W-1:0] byte0_q, byte0_d;
	logic              hi_nz_q, hi_nz_d;
	logic [LW-1:0]     ncnt_q, ncnt_d;

	logic hdr_pend_s1, hdr_pend_d;
	logic dat_pend_s1, dat_pend_d;
	logic dat_last_s1, dat_last_d;

	logic              skid_v_q, skid_v_d;
	logic [BYTE_W-1:0] skid_byte_q, skid_byte_d;
	logic              skid_last_q, skid_last_d;

	logic                    out_v_q, out_v_d;
	logic [STATUS_W-1:0]     out_status_q, out_status_d;
	logic [BYTE_W-1:0]       out_byte_q, out_byte_d;
	logic                    out_bv_q, out_bv_d;
	logic                    out_last_q, out_last_d;
	logic [FREE_BYTES_W-1:0] out_free_q, out_free_d;
	logic                    out_empty_q, out_empty_d;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;

	logic          out_free, is_empty_now, issue_ok, room_ok;
	logic [LW-1:0] len_w, n_w;
	logic [SW-1:0] rp_sum;
	logic [CW-1:0] free_sum;

	lprr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RING_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - 18)'(0), out_empty_q, out_free_q, out_byte_q};
	assign m_axis_tuser  = {out_bv_q, out_status_q};

	assign out_free     = !out_v_q || m_axis_tready;
	assign is_empty_now = (free_q == FW'(RING_BYTES));
	// The skid stage takes at most one byte, so a read is held back whenever the byte
	// arriving now would have to wait there.
	assign issue_ok     = !skid_v_q && !(dat_pend_s1 && !out_free);
	assign room_ok      = (CW'(rec_len_q) <= CW'(MAX_RECORD)) &&
	                      (CW'(free_q) >= CW'(HEADER_BYTES) + CW'(rec_len_q));

	// Stored lengths are clamped to MAX_RECORD, including any non-zero upper header byte.
	assign len_w    = (hi_nz_q || byte0_q > 8'(MAX_RECORD)) ? LW'(MAX_RECORD)
	                                                        : byte0_q[LW-1:0];
	assign n_w      = (CW'(max_len_q) < CW'(len_w)) ? LW'(max_len_q) : len_w;
	assign rp_sum   = SW'(scan_q) + SW'(len_w);
	assign free_sum = CW'(free_q) + CW'(HEADER_BYTES) + CW'(len_w);

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		rec_len_d    = rec_len_q;
		max_len_d    = max_len_q;
		byte_d       = byte_q;
		status_d     = status_q;
		rp_d         = rp_q;
		wp_d         = wp_q;
		scan_d       = scan_q;
		free_d       = free_q;
		push_open_d  = push_open_q;
		push_rem_d   = push_rem_q;
		hcnt_d       = hcnt_q;
		hrcv_d       = hrcv_q;
		byte0_d      = byte0_q;
		hi_nz_d      = hi_nz_q;
		ncnt_d       = ncnt_q;
		hdr_pend_d   = 1'b0;
		dat_pend_d   = 1'b0;
		dat_last_d   = 1'b0;
		skid_v_d     = skid_v_q;
		skid_byte_d  = skid_byte_q;
		skid_last_d  = skid_last_q;
		out_v_d      = out_v_q && !m_axis_tready;
		out_status_d = out_status_q;
		out_byte_d   = out_byte_q;
		out_bv_d     = out_bv_q;
		out_last_d   = out_last_q;
		out_free_d   = out_free_q;
		out_empty_d  = out_empty_q;
		mem_we       = 1'b0;
		mem_waddr    = wp_q;
		mem_wdata    = byte_q;
		mem_re       = 1'b0;
		mem_raddr    = scan_q;

		// Byte results: the skid entry is older than a byte arriving in the same cycle.
		if (out_free) begin
			if (skid_v_q) begin
				out_v_d      = 1'b1;
				out_status_d = STATUS_OK;
				out_byte_d   = skid_byte_q;
				out_bv_d     = 1'b1;
				out_last_d   = skid_last_q;
				out_free_d   = FREE_BYTES_W'(free_q);
				out_empty_d  = is_empty_now;
				skid_v_d     = dat_pend_s1;
				skid_byte_d  = mem_rdata;
				skid_last_d  = dat_last_s1;
			end else if (dat_pend_s1) begin
				out_v_d      = 1'b1;
				out_status_d = STATUS_OK;
				out_byte_d   = mem_rdata;
				out_bv_d     = 1'b1;
				out_last_d   = dat_last_s1;
				out_free_d   = FREE_BYTES_W'(free_q);
				out_empty_d  = is_empty_now;
			end
		end else if (dat_pend_s1) begin
			skid_v_d    = 1'b1;
			skid_byte_d = mem_rdata;
			skid_last_d = dat_last_s1;
		end

		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					kind_d    = s_axis_tuser;
					rec_len_d = s_axis_tdata[5:0];
					max_len_d = s_axis_tdata[11:6];
					byte_d    = s_axis_tdata[19:12];
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				status_d = STATUS_OK;
				state_d  = ST_RESULT;
				hcnt_d   = '0;
				hrcv_d   = '0;
				byte0_d  = '0;
				hi_nz_d  = 1'b0;
				scan_d   = rp_q;
				case (kind_q)
					KIND_BEGIN: begin
						if (push_open_q) begin
							status_d = STATUS_ORDER;
						end else if (!room_ok) begin
							status_d = STATUS_NOROOM;
						end else begin
							free_d      = FW'(CW'(free_q) - CW'(HEADER_BYTES) - CW'(rec_len_q));
							push_rem_d  = rec_len_q;
							push_open_d = (rec_len_q != '0);
							state_d     = ST_HDR_WR;
						end
					end
					KIND_DATA: begin
						if (!push_open_q) begin
							status_d = STATUS_ORDER;
						end else begin
							mem_we      = 1'b1;
							wp_d        = ring_next(wp_q);
							push_rem_d  = push_rem_q - 1'b1;
							push_open_d = (push_rem_q != LEN_W'(1));
						end
					end
					KIND_POP, KIND_PEEK: begin
						if (push_open_q) begin
							status_d = STATUS_ORDER;
						end else if (is_empty_now) begin
							status_d = STATUS_EMPTY;
						end else begin
							state_d = ST_HDR_RD;
						end
					end
					KIND_CLEAR: begin
						wp_d        = rp_q;
						free_d      = FW'(RING_BYTES);
						push_open_d = 1'b0;
						push_rem_d  = '0;
					end
					default: begin
						status_d = STATUS_ORDER;
					end
				endcase
			end
			ST_HDR_WR: begin
				mem_we    = 1'b1;
				mem_wdata = (hcnt_q == '0) ? BYTE_W'(rec_len_q) : '0;
				wp_d      = ring_next(wp_q);
				hcnt_d    = hcnt_q + 1'b1;
				if (hcnt_q == HCW'(HEADER_BYTES - 1)) begin
					state_d = ST_RESULT;
				end
			end
			ST_HDR_RD: begin
				if (hcnt_q != HCW'(HEADER_BYTES)) begin
					mem_re     = 1'b1;
					scan_d     = ring_next(scan_q);
					hcnt_d     = hcnt_q + 1'b1;
					hdr_pend_d = 1'b1;
				end
				if (hdr_pend_s1) begin
					if (hrcv_q == '0) begin
						byte0_d = mem_rdata;
					end else begin
						hi_nz_d = hi_nz_q || (mem_rdata != '0);
					end
					hrcv_d = hrcv_q + 1'b1;
					if (hrcv_q == HCW'(HEADER_BYTES - 1)) begin
						state_d = ST_LEN;
					end
				end
			end
			ST_LEN: begin
				// scan_q now points at the first data byte.
				if (kind_q == KIND_POP) begin
					rp_d   = (rp_sum >= SW'(RING_BYTES)) ? AW'(rp_sum - SW'(RING_BYTES))
					                                     : AW'(rp_sum);
					free_d = (free_sum > CW'(RING_BYTES)) ? FW'(RING_BYTES) : FW'(free_sum);
				end
				ncnt_d   = n_w;
				status_d = STATUS_OK;
				state_d  = (n_w == '0) ? ST_RESULT : ST_DATA_RD;
			end
			ST_DATA_RD: begin
				if (issue_ok) begin
					mem_re     = 1'b1;
					scan_d     = ring_next(scan_q);
					dat_pend_d = 1'b1;
					dat_last_d = (ncnt_q == LW'(1));
					ncnt_d     = ncnt_q - 1'b1;
					if (ncnt_q == LW'(1)) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!dat_pend_s1 && !skid_v_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					out_v_d      = 1'b1;
					out_status_d = status_q;
					out_byte_d   = '0;
					out_bv_d     = 1'b0;
					out_last_d   = 1'b1;
					out_free_d   = FREE_BYTES_W'(free_q);
					out_empty_d  = is_empty_now;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			free_q      <= FW'(RING_BYTES);
			push_open_q <= 1'b0;
			push_rem_q  <= '0;
			hdr_pend_s1 <= 1'b0;
			dat_pend_s1 <= 1'b0;
			skid_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			rp_q        <= rp_d;
			wp_q        <= wp_d;
			free_q      <= free_d;
			push_open_q <= push_open_d;
			push_rem_q  <= push_rem_d;
			hdr_pend_s1 <= hdr_pend_d;
			dat_pend_s1 <= dat_pend_d;
			skid_v_q    <= skid_v_d;
			out_v_q     <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q       <= kind_d;
		rec_len_q    <= rec_len_d;
		max_len_q    <= max_len_d;
		byte_q       <= byte_d;
		status_q     <= status_d;
		scan_q       <= scan_d;
		hcnt_q       <= hcnt_d;
		hrcv_q       <= hrcv_d;
		byte0_q      <= byte0_d;
		hi_nz_q      <= hi_nz_d;
		ncnt_q       <= ncnt_d;
		dat_last_s1  <= dat_last_d;
		skid_byte_q  <= skid_byte_d;
		skid_last_q  <= skid_last_d;
		out_status_q <= out_status_d;
		out_byte_q   <= out_byte_d;
		out_bv_q     <= out_bv_d;
		out_last_q   <= out_last_d;
		out_free_q   <= out_free_d;
		out_empty_q  <= out_empty_d;
	end

	// A byte may only land in the skid stage when it is empty.
	a_skid_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(dat_pend_s1 && !out_free) |-> !skid_v_q)
		else $error("skid stage overrun");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FW'(RING_BYTES))
		else $error("free count above ring size");

	a_push_open_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		push_open_q == (push_rem_q != '0))
		else $error("open push flag disagrees with remaining count");

	// No memory read may still be in flight once a new request can be taken.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!dat_pend_s1 && !hdr_pend_s1 && !skid_v_q))
		else $error("read in flight while idle");

endmodule
